>>> rtl/core/quadratic_lagrange_derivative_top_defines.svh
// Assertion macros used by the quadratic Lagrange derivative top level.
`ifndef QUADRATIC_LAGRANGE_DERIVATIVE_TOP_DEFINES_SVH
`define QUADRATIC_LAGRANGE_DERIVATIVE_TOP_DEFINES_SVH

// Check that a consequence holds in the same cycle.
`define QLD_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("qld assertion failed");

// Check that a consequence holds in the next cycle.
`define QLD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("qld assertion failed");

`endif

>>> rtl/core/qld_pkg.sv
// Package with widths, types and latency of the quadratic Lagrange derivative.
package qld_pkg;

  localparam int W     = 32;
  localparam int F     = 16;
  localparam int NUMW  = W + 2;
  localparam int PRODW = 2 * W + 2;
  localparam int DENW  = 2 * W;
  localparam int MAGW  = 2 * W + F;
  localparam int DMAGW = 2 * W - 1;
  localparam int QSW   = MAGW + 1;
  localparam int SUMW  = MAGW + 3;
  localparam int LAT   = MAGW + 5;

  typedef logic signed [W-1:0]     word_t;
  typedef logic signed [NUMW-1:0]  num_t;
  typedef logic signed [PRODW-1:0] prod_t;
  typedef logic signed [DENW-1:0]  den_t;
  typedef logic signed [QSW-1:0]   qs_t;
  typedef logic signed [SUMW-1:0]  sum_t;

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic             zero;
    logic [MAGW-1:0]  nq;
    logic [DMAGW-1:0] d;
    logic [DMAGW-1:0] rem;
  } div_t;

endpackage

>>> rtl/core/qld_prep.sv
// Front stages: clamp, numerators, products and magnitudes for the three terms.
module qld_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  qld_pkg::word_t query_time,
  input  qld_pkg::word_t sample_newest,
  input  qld_pkg::word_t sample_middle,
  input  qld_pkg::word_t sample_oldest,
  input  qld_pkg::word_t span_total,
  input  qld_pkg::word_t span_late,
  input  qld_pkg::word_t span_early,
  input  qld_pkg::word_t time_newest,
  input  qld_pkg::word_t time_middle,
  input  qld_pkg::word_t time_oldest,
  output qld_pkg::div_t  term0,
  output qld_pkg::div_t  term1,
  output qld_pkg::div_t  term2
);
  import qld_pkg::*;

  function automatic num_t sx(input word_t v);
    sx = {{(NUMW-W){v[W-1]}}, v};
  endfunction

  word_t t_lo, t_cl;
  num_t  two_t;
  num_t  n0_nxt, n1_nxt, n2_nxt;
  logic  zero_nxt;

  logic  v1_r, z1_r;
  num_t  n0_r, n1_r, n2_r;
  word_t so_r, sm_r, sn_r, st_r, sl_r, se_r;

  logic  v2_r, z2_r;
  prod_t p0_r, p1_r, p2_r;
  den_t  d0_r, d1_r, d2_r;

  prod_t a0, a1, a2;
  den_t  b0, b1, b2;

  always_comb begin
    t_lo     = (query_time < time_oldest) ? time_oldest : query_time;
    t_cl     = (time_newest < t_lo) ? time_newest : t_lo;
    two_t    = {t_cl[W-1], t_cl, 1'b0};
    n0_nxt   = two_t - sx(time_newest) - sx(time_middle);
    n1_nxt   = two_t - sx(time_newest) - sx(time_oldest);
    n2_nxt   = two_t - sx(time_middle) - sx(time_oldest);
    zero_nxt = (span_total == '0) || (span_late == '0) || (span_early == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    z1_r <= zero_nxt;
    n0_r <= n0_nxt;
    n1_r <= n1_nxt;
    n2_r <= n2_nxt;
    so_r <= sample_oldest;
    sm_r <= sample_middle;
    sn_r <= sample_newest;
    st_r <= span_total;
    sl_r <= span_late;
    se_r <= span_early;
  end

  always_ff @(posedge clk) begin
    z2_r <= z1_r;
    p0_r <= so_r * n0_r;
    p1_r <= sm_r * n1_r;
    p2_r <= sn_r * n2_r;
    d0_r <= se_r * st_r;
    d1_r <= se_r * sl_r;
    d2_r <= st_r * sl_r;
  end

  always_comb begin
    a0 = p0_r[PRODW-1] ? -p0_r : p0_r;
    a1 = p1_r[PRODW-1] ? -p1_r : p1_r;
    a2 = p2_r[PRODW-1] ? -p2_r : p2_r;
    b0 = d0_r[DENW-1] ? -d0_r : d0_r;
    b1 = d1_r[DENW-1] ? -d1_r : d1_r;
    b2 = d2_r[DENW-1] ? -d2_r : d2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term0.valid <= 1'b0;
      term1.valid <= 1'b0;
      term2.valid <= 1'b0;
    end else begin
      term0.valid <= v2_r;
      term1.valid <= v2_r;
      term2.valid <= v2_r;
    end
    term0.neg  <= p0_r[PRODW-1] ^ d0_r[DENW-1];
    term1.neg  <= ~(p1_r[PRODW-1] ^ d1_r[DENW-1]);
    term2.neg  <= p2_r[PRODW-1] ^ d2_r[DENW-1];
    term0.zero <= z2_r;
    term1.zero <= z2_r;
    term2.zero <= z2_r;
    term0.nq   <= {a0[2*W-1:0], {F{1'b0}}};
    term1.nq   <= {a1[2*W-1:0], {F{1'b0}}};
    term2.nq   <= {a2[2*W-1:0], {F{1'b0}}};
    term0.d    <= b0[DMAGW-1:0];
    term1.d    <= b1[DMAGW-1:0];
    term2.d    <= b2[DMAGW-1:0];
    term0.rem  <= '0;
    term1.rem  <= '0;
    term2.rem  <= '0;
  end

endmodule

>>> rtl/core/qld_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module qld_div (
  input  logic          clk,
  input  logic          rst_n,
  input  qld_pkg::div_t din,
  output qld_pkg::div_t dout
);
  import qld_pkg::*;

  div_t stage_r [0:MAGW-1];

  genvar g;
  generate
    for (g = 0; g < MAGW; g++) begin : g_stage
      div_t                src;
      logic [DMAGW:0]      shifted;
      logic [DMAGW+1:0]    diff;
      logic                ge;
      if (g == 0) begin : g_first
        assign src = din;
      end else begin : g_rest
        assign src = stage_r[g-1];
      end
      always_comb begin
        shifted = {src.rem, src.nq[MAGW-1]};
        diff    = {1'b0, shifted} - {2'b00, src.d};
        ge      = ~diff[DMAGW+1];
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stage_r[g].valid <= 1'b0;
        end else begin
          stage_r[g].valid <= src.valid;
        end
        stage_r[g].neg  <= src.neg;
        stage_r[g].zero <= src.zero;
        stage_r[g].d    <= src.d;
        stage_r[g].nq   <= {src.nq[MAGW-2:0], ge};
        stage_r[g].rem  <= ge ? diff[DMAGW-1:0] : shifted[DMAGW-1:0];
      end
    end
  endgenerate

  assign dout = stage_r[MAGW-1];

endmodule

>>> rtl/core/qld_post.sv
// Back stages: sign the quotients, sum, saturate, force zero on a zero span and drive the result.
module qld_post (
  input  logic           clk,
  input  logic           rst_n,
  input  qld_pkg::div_t  q0,
  input  qld_pkg::div_t  q1,
  input  qld_pkg::div_t  q2,
  output logic           out_valid,
  output qld_pkg::word_t out_slope,
  output logic           out_error_flag
);
  import qld_pkg::*;

  logic v_r, z_r;
  qs_t  s0_r, s1_r, s2_r;
  sum_t sum;
  logic ovf;
  word_t wmax;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_r       <= q0.valid;
      out_valid <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    z_r  <= q0.zero | q1.zero | q2.zero;
    s0_r <= q0.neg ? -qs_t'({1'b0, q0.nq}) : qs_t'({1'b0, q0.nq});
    s1_r <= q1.neg ? -qs_t'({1'b0, q1.nq}) : qs_t'({1'b0, q1.nq});
    s2_r <= q2.neg ? -qs_t'({1'b0, q2.nq}) : qs_t'({1'b0, q2.nq});
  end

  always_comb begin
    sum  = sum_t'(s0_r) + sum_t'(s1_r) + sum_t'(s2_r);
    ovf  = !((&sum[SUMW-1:W-1]) || !(|sum[SUMW-1:W-1]));
    wmax = {1'b0, {(W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (z_r) begin
      out_slope      <= '0;
      out_error_flag <= 1'b1;
    end else if (ovf) begin
      out_slope      <= sum[SUMW-1] ? ~wmax : wmax;
      out_error_flag <= 1'b1;
    end else begin
      out_slope      <= sum[W-1:0];
      out_error_flag <= 1'b0;
    end
  end

endmodule

>>> rtl/core/quadratic_lagrange_derivative_top.sv
// Top level of the quadratic Lagrange derivative pipeline.
//   channel  ports                      handshake
//   input    start, busy, in_*          taken when start && !busy
//   result   out_valid, out_slope, ...  one-cycle strobe, no backpressure
// One transaction enters per cycle; busy stays low.
// The pipeline has three front stages, 80 divider stages and two back stages.
// The divider pipeline (one quotient bit per stage, three in parallel) sets the latency.
// Reset clears only the valid bits; data registers keep running.
// The pipeline never stalls since results cannot be held off.
`include "quadratic_lagrange_derivative_top_defines.svh"
module quadratic_lagrange_derivative_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  qld_pkg::word_t in_query_time,
  input  qld_pkg::word_t in_sample_newest,
  input  qld_pkg::word_t in_sample_middle,
  input  qld_pkg::word_t in_sample_oldest,
  input  qld_pkg::word_t in_span_total,
  input  qld_pkg::word_t in_span_late,
  input  qld_pkg::word_t in_span_early,
  input  qld_pkg::word_t in_time_newest,
  input  qld_pkg::word_t in_time_middle,
  input  qld_pkg::word_t in_time_oldest,
  output logic           out_valid,
  output qld_pkg::word_t out_slope,
  output logic           out_error_flag
);
  import qld_pkg::*;

  div_t t0, t1, t2;
  div_t q0, q1, q2;

  assign busy = 1'b0;

  qld_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (start && !busy),
    .query_time    (in_query_time),
    .sample_newest (in_sample_newest),
    .sample_middle (in_sample_middle),
    .sample_oldest (in_sample_oldest),
    .span_total    (in_span_total),
    .span_late     (in_span_late),
    .span_early    (in_span_early),
    .time_newest   (in_time_newest),
    .time_middle   (in_time_middle),
    .time_oldest   (in_time_oldest),
    .term0         (t0),
    .term1         (t1),
    .term2         (t2)
  );

  qld_div u_div0 (.clk(clk), .rst_n(rst_n), .din(t0), .dout(q0));
  qld_div u_div1 (.clk(clk), .rst_n(rst_n), .din(t1), .dout(q1));
  qld_div u_div2 (.clk(clk), .rst_n(rst_n), .din(t2), .dout(q2));

  qld_post u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .q0             (q0),
    .q1             (q1),
    .q2             (q2),
    .out_valid      (out_valid),
    .out_slope      (out_slope),
    .out_error_flag (out_error_flag)
  );

  `QLD_ASSERT_SAME(a_latency, start && !busy, ##LAT out_valid)
  `QLD_ASSERT_SAME(a_no_orphan, out_valid, $past(start, LAT))
  `QLD_ASSERT_SAME(a_zero_span, start && !busy && in_span_total == '0,
                   ##LAT (out_error_flag && out_slope == '0))
  `QLD_ASSERT_SAME(a_lanes_align, q0.valid, q1.valid && q2.valid && q0.zero == q2.zero)

endmodule
